FILE: rtl/sls_pkg.sv
// Shared types, constants and helper functions of the status LED sequencer.
package sls_pkg;

   // Strip geometry and default text length.
   localparam int LED_COUNT        = 15;
   localparam int TEXT_LEN_DEFAULT = 16;

   // Command codes of the request word.
   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_LINK = 2'd1;
   localparam logic [1:0] CMD_CHAR = 2'd2;

   // Register indexes of the CSR port.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_AP_MODE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BLINK_PER   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_AMBER_PER   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DIGIT_PER   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_GAP_PER     = 3'd4;

   // Register reset values.
   localparam logic [15:0] BLINK_PER_RESET = 16'd200;
   localparam logic [15:0] AMBER_PER_RESET = 16'd40;
   localparam logic [15:0] DIGIT_PER_RESET = 16'd400;
   localparam logic [15:0] GAP_PER_RESET   = 16'd40;
   localparam logic [15:0] DIGIT_RESET     = 16'd400;

   // Color levels.
   localparam logic [7:0] DIM_LEVEL   = 8'd25;
   localparam logic [7:0] AMBER_GREEN = 8'd20;
   localparam logic [7:0] GAP_GREY    = 8'h30;
   localparam logic [7:0] DOT_GREY    = 8'hb0;
   localparam logic [7:0] FULL_LEVEL  = 8'hFF;

   // Digit color sequence.
   localparam logic [1:0] COLOUR_RED   = 2'd0;
   localparam logic [1:0] COLOUR_GREEN = 2'd1;
   localparam logic [1:0] COLOUR_BLUE  = 2'd2;

   // Characters with a meaning on the strips.
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_ONE  = 8'h31;
   localparam logic [7:0] CHAR_FIVE = 8'h35;
   localparam logic [7:0] CHAR_SIX  = 8'h36;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_DOT  = 8'h2E;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       link_up;
      logic [3:0] char_index;
      logic [7:0] char_code;
   } req_word_type;

   typedef struct packed {
      logic                 show;
      logic [7:0]           fill1_red;
      logic [7:0]           fill1_green;
      logic [7:0]           fill1_blue;
      logic [7:0]           fill2_red;
      logic [7:0]           fill2_green;
      logic [7:0]           fill2_blue;
      logic [LED_COUNT-1:0] lit_mask;
      logic [7:0]           lit_red;
      logic [7:0]           lit_green;
      logic [7:0]           lit_blue;
      logic                 cycle_done;
   } rsp_word_type;

   typedef struct packed {
      logic        ap_mode;
      logic [15:0] blink_period;
      logic [15:0] amber_on_period;
      logic [15:0] digit_period;
      logic [15:0] gap_period;
   } cfg_type;

   // Mask with count LEDs lit from LED start; LEDs past the strip stay dark.
   function automatic logic [LED_COUNT-1:0] run_bits(input int start, input int count);
      logic [LED_COUNT-1:0] m;
      m = '0;
      for (int i = 0; i < LED_COUNT; i++) begin
         m[i] = (i >= start) && (i < start + count);
      end
      return m;
   endfunction

   // LED pattern of one address character.
   function automatic logic [LED_COUNT-1:0] char_mask(input logic [7:0] c);
      logic [LED_COUNT-1:0] m;
      m = '0;
      if (c >= CHAR_ONE && c <= CHAR_FIVE) begin
         m = run_bits(0, int'(c) - int'(CHAR_ZERO));
      end else if (c >= CHAR_SIX && c <= CHAR_NINE) begin
         m = run_bits(0, 5) | run_bits(8, int'(c) - int'(CHAR_FIVE));
      end else if (c == CHAR_DOT) begin
         m = run_bits(0, 1) | run_bits(5, 1) | run_bits(10, 1);
      end
      return m;
   endfunction

endpackage

FILE: rtl/sls_text_store.sv
// Address text storage with write port and two read ports.
module sls_text_store #(
   parameter int TEXT_LEN = sls_pkg::TEXT_LEN_DEFAULT,
   parameter int POS_W    = $clog2(TEXT_LEN + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [3:0]       wr_index,
   input  logic [7:0]       wr_data,
   input  logic [POS_W-1:0] rd_pos,
   output logic [7:0]       rd_char_pos,
   output logic [7:0]       rd_char_first
);
   import sls_pkg::*;

   localparam int IDX_W = $clog2(TEXT_LEN);

   logic [7:0] text_ff [TEXT_LEN];
   logic [IDX_W-1:0] wr_addr;

   // Write address; indexes past the store are dropped.
   assign wr_addr = IDX_W'(wr_index);

   // Text registers clear at reset, one character written per word.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TEXT_LEN; i++) begin
            text_ff[i] <= '0;
         end
      end else if (wr_en && (int'(wr_index) < TEXT_LEN)) begin
         text_ff[wr_addr] <= wr_data;
      end
   end

   // A position past the end reads as a terminator.
   always_comb begin
      rd_char_pos = '0;
      if (int'(rd_pos) < TEXT_LEN) begin
         rd_char_pos = text_ff[rd_pos[IDX_W-1:0]];
      end
      rd_char_first = text_ff[0];
   end

endmodule

FILE: rtl/sls_pattern_engine.sv
// Sequencer state and next-state logic for blink and address display.
module sls_pattern_engine #(
   parameter int TEXT_LEN = sls_pkg::TEXT_LEN_DEFAULT,
   parameter int POS_W    = $clog2(TEXT_LEN + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  sls_pkg::req_word_type req_word,
   input  sls_pkg::cfg_type      cfg,
   input  logic [7:0]           char_pos,
   input  logic [7:0]           char_first,
   output logic [POS_W-1:0]     text_pos,
   output sls_pkg::rsp_word_type rsp_next
);
   import sls_pkg::*;

   logic                 linked_ff, linked_in;
   logic                 phase_ff, phase_in;
   logic [15:0]          blink_timer_ff, blink_timer_in;
   logic [POS_W-1:0]     text_pos_ff, text_pos_in;
   logic [1:0]           colour_ff, colour_in;
   logic [15:0]          digit_timer_ff, digit_timer_in;
   logic                 in_gap_ff, in_gap_in;
   logic                 done_ff, done_in;
   rgb_type              fill1_ff, fill1_in;
   rgb_type              fill2_ff, fill2_in;
   logic [LED_COUNT-1:0] lit_mask_ff, lit_mask_in;
   rgb_type              lit_rgb_ff, lit_rgb_in;

   assign text_pos = text_pos_ff;

   // Next state for one accepted word.
   always_comb begin
      logic [15:0]          dt;
      logic [POS_W-1:0]     pos;
      logic [1:0]           col;
      logic [7:0]           ch;
      logic [LED_COUNT-1:0] mask;
      rgb_type              rgb;
      rgb_type              black;
      rgb_type              grey;
      black = '0;
      grey  = '{red: GAP_GREY, green: GAP_GREY, blue: GAP_GREY};
      dt    = digit_timer_ff - 16'd1;
      pos   = text_pos_ff;
      col   = colour_ff;
      ch    = char_pos;
      mask  = '0;
      rgb   = '0;
      linked_in      = linked_ff;
      phase_in       = phase_ff;
      blink_timer_in = blink_timer_ff;
      text_pos_in    = text_pos_ff;
      colour_in      = colour_ff;
      digit_timer_in = digit_timer_ff;
      in_gap_in      = in_gap_ff;
      done_in        = done_ff;
      fill1_in       = fill1_ff;
      fill2_in       = fill2_ff;
      lit_mask_in    = lit_mask_ff;
      lit_rgb_in     = lit_rgb_ff;
      if (accept) begin
         unique case (req_word.cmd)
            CMD_TICK: begin
               if (!cfg.ap_mode && linked_ff) begin
                  // Address display countdown.
                  digit_timer_in = dt;
                  if (dt == 16'd0) begin
                     lit_mask_in = '0;
                     lit_rgb_in  = '0;
                     if (in_gap_ff) begin
                        fill1_in       = grey;
                        fill2_in       = grey;
                        digit_timer_in = cfg.gap_period;
                        in_gap_in      = 1'b0;
                     end else begin
                        in_gap_in      = 1'b1;
                        digit_timer_in = cfg.digit_period;
                        if (char_pos == 8'd0) begin
                           // End of text: restart with the next color.
                           pos = '0;
                           ch  = char_first;
                           if (col == COLOUR_BLUE) begin
                              col     = COLOUR_RED;
                              done_in = 1'b1;
                           end else begin
                              col = 2'(col + 2'd1);
                           end
                        end
                        text_pos_in = POS_W'(pos + 1'b1);
                        colour_in   = col;
                        fill1_in    = black;
                        fill2_in    = black;
                        mask        = char_mask(ch);
                        if (ch == CHAR_DOT) begin
                           rgb = '{red: DOT_GREY, green: DOT_GREY, blue: DOT_GREY};
                        end else begin
                           rgb.red   = (col == COLOUR_RED)   ? FULL_LEVEL : 8'd0;
                           rgb.green = (col == COLOUR_GREEN) ? FULL_LEVEL : 8'd0;
                           rgb.blue  = (col == COLOUR_BLUE)  ? FULL_LEVEL : 8'd0;
                        end
                        lit_mask_in = mask;
                        if (mask != '0) begin
                           lit_rgb_in = rgb;
                        end
                     end
                  end
               end else if (blink_timer_ff != 16'd0) begin
                  blink_timer_in = blink_timer_ff - 16'd1;
               end else begin
                  // Blink phase change.
                  lit_mask_in = '0;
                  lit_rgb_in  = '0;
                  phase_in    = !phase_ff;
                  fill1_in    = black;
                  fill2_in    = black;
                  if (cfg.ap_mode) begin
                     blink_timer_in = cfg.blink_period;
                     if (linked_ff) begin
                        if (!phase_ff) begin
                           fill1_in = '{red: 8'd0, green: DIM_LEVEL, blue: DIM_LEVEL};
                           fill2_in = '{red: 8'd0, green: DIM_LEVEL, blue: DIM_LEVEL};
                        end
                     end else if (!phase_ff) begin
                        fill1_in.blue = DIM_LEVEL;
                     end else begin
                        fill2_in.blue = DIM_LEVEL;
                     end
                  end else if (!phase_ff) begin
                     blink_timer_in = cfg.amber_on_period;
                     fill1_in = '{red: DIM_LEVEL, green: AMBER_GREEN, blue: 8'd0};
                     fill2_in = '{red: DIM_LEVEL, green: AMBER_GREEN, blue: 8'd0};
                  end else begin
                     blink_timer_in = cfg.blink_period;
                  end
               end
            end
            CMD_LINK: begin
               if (req_word.link_up) begin
                  text_pos_in    = '0;
                  colour_in      = COLOUR_RED;
                  done_in        = 1'b0;
                  digit_timer_in = cfg.digit_period;
                  in_gap_in      = 1'b0;
               end
               linked_in = req_word.link_up;
            end
            default: begin
            end
         endcase
      end
   end

   // Result word reflects the state after this word.
   always_comb begin
      rsp_next.show        = accept && (req_word.cmd == CMD_TICK);
      rsp_next.fill1_red   = fill1_in.red;
      rsp_next.fill1_green = fill1_in.green;
      rsp_next.fill1_blue  = fill1_in.blue;
      rsp_next.fill2_red   = fill2_in.red;
      rsp_next.fill2_green = fill2_in.green;
      rsp_next.fill2_blue  = fill2_in.blue;
      rsp_next.lit_mask    = lit_mask_in;
      rsp_next.lit_red     = lit_rgb_in.red;
      rsp_next.lit_green   = lit_rgb_in.green;
      rsp_next.lit_blue    = lit_rgb_in.blue;
      rsp_next.cycle_done  = done_in;
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         linked_ff      <= 1'b0;
         phase_ff       <= 1'b0;
         blink_timer_ff <= '0;
         text_pos_ff    <= '0;
         colour_ff      <= COLOUR_RED;
         digit_timer_ff <= DIGIT_RESET;
         in_gap_ff      <= 1'b0;
         done_ff        <= 1'b0;
         fill1_ff       <= '0;
         fill2_ff       <= '0;
         lit_mask_ff    <= '0;
         lit_rgb_ff     <= '0;
      end else begin
         linked_ff      <= linked_in;
         phase_ff       <= phase_in;
         blink_timer_ff <= blink_timer_in;
         text_pos_ff    <= text_pos_in;
         colour_ff      <= colour_in;
         digit_timer_ff <= digit_timer_in;
         in_gap_ff      <= in_gap_in;
         done_ff        <= done_in;
         fill1_ff       <= fill1_in;
         fill2_ff       <= fill2_in;
         lit_mask_ff    <= lit_mask_in;
         lit_rgb_ff     <= lit_rgb_in;
      end
   end

endmodule

FILE: rtl/status_led_blink_and_ip_digit_sequencer.sv
// Top level of the status LED sequencer: CSRs, sequencer and result register.
//
// Usage:
//   The request channel (req_valid, req_stall, req_word) carries one word per
//   tick, link event or address character write. Every accepted request word
//   yields exactly one result word on the rsp channel, holding the strip
//   contents after that word and show set for ticks.
//   A word is accepted when valid is high and stall is low.
//   The result is in the output register on the clock after acceptance.
//   Throughput is one word per cycle while the receiver does not stall, set by
//   the single state register update in the sequencer.
//   While the receiver stalls a pending result, the result register holds its
//   word and req_stall is raised, so at most one result waits at a time.
//   CSRs are written through csr_we, csr_index and csr_wdata while idle.
//   Synchronous reset restores register defaults, clears the address text,
//   the strip colors and drops any pending result.
module status_led_blink_and_ip_digit_sequencer #(
   parameter int TEXT_LEN = sls_pkg::TEXT_LEN_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  sls_pkg::req_word_type           req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output sls_pkg::rsp_word_type           rsp_word,
   input  logic                            csr_we,
   input  logic [sls_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                     csr_wdata
);
   import sls_pkg::*;

   localparam int POS_W = $clog2(TEXT_LEN + 1);

   cfg_type          cfg_ff;
   logic             accept;
   logic [POS_W-1:0] text_pos;
   logic [7:0]       char_pos;
   logic [7:0]       char_first;
   rsp_word_type     rsp_next;
   logic             rsp_valid_ff;
   rsp_word_type     rsp_word_ff;

   // Handshake: take a word whenever the output register can move.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ap_mode         <= 1'b0;
         cfg_ff.blink_period    <= BLINK_PER_RESET;
         cfg_ff.amber_on_period <= AMBER_PER_RESET;
         cfg_ff.digit_period    <= DIGIT_PER_RESET;
         cfg_ff.gap_period      <= GAP_PER_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_AP_MODE:   cfg_ff.ap_mode         <= csr_wdata[0];
            REG_BLINK_PER: cfg_ff.blink_period    <= csr_wdata;
            REG_AMBER_PER: cfg_ff.amber_on_period <= csr_wdata;
            REG_DIGIT_PER: cfg_ff.digit_period    <= csr_wdata;
            REG_GAP_PER:   cfg_ff.gap_period      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   sls_text_store #(
      .TEXT_LEN (TEXT_LEN),
      .POS_W    (POS_W)
   ) u_text (
      .clock         (clock),
      .reset         (reset),
      .wr_en         (accept && (req_word.cmd == CMD_CHAR)),
      .wr_index      (req_word.char_index),
      .wr_data       (req_word.char_code),
      .rd_pos        (text_pos),
      .rd_char_pos   (char_pos),
      .rd_char_first (char_first)
   );

   sls_pattern_engine #(
      .TEXT_LEN (TEXT_LEN),
      .POS_W    (POS_W)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_word   (req_word),
      .cfg        (cfg_ff),
      .char_pos   (char_pos),
      .char_first (char_first),
      .text_pos   (text_pos),
      .rsp_next   (rsp_next)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff <= rsp_next;
      end
   end

   // A reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // Each accepted word shows up as a result, flagged as shown only for ticks.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid && (rsp_word.show == ($past(req_word.cmd) == CMD_TICK)))
      else $error("result missing or show flag wrong");

   // The highlight color is black whenever nothing is highlighted.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.lit_mask == '0) |->
         (rsp_word.lit_red == 8'd0 && rsp_word.lit_green == 8'd0 &&
          rsp_word.lit_blue == 8'd0))
      else $error("highlight color without lit LEDs");

   // A waiting result is never overwritten by a new word.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_word_ff))
      else $error("stalled result changed");

endmodule

FILE: tb/sv/status_led_blink_and_ip_digit_sequencer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the status LED sequencer with a behavioral strip predictor.
module status_led_blink_and_ip_digit_sequencer_tb;
   import sls_pkg::*;

   // The fourth command code is left unused by the block.
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int TEXT_LEN = TEXT_LEN_DEFAULT;
   localparam int ITEMS_TARGET = 1650;
   localparam int PHASE_WORDS = 150;
   localparam int DRAIN_LIMIT = 10000;

   // Predicts the strip contents after every request word and checks the result words.
   class strip_predictor;
      // Copies of the registers.
      logic ap_mode;
      logic [15:0] blink_period, amber_period, digit_period, gap_period;
      // Sequencer state.
      logic linked, blink_phase, gap_next, done;
      logic [15:0] blink_count, digit_count;
      logic [7:0] addr_text[TEXT_LEN];
      int text_pos;
      logic [1:0] colour;
      rgb_type fill1, fill2, lit_rgb;
      logic [LED_COUNT-1:0] lit_mask;
      rsp_word_type expected_strips[$];
      int errors, checked, done_events;

      function new();
         ap_mode = 1'b0;
         blink_period = BLINK_PER_RESET;
         amber_period = AMBER_PER_RESET;
         digit_period = DIGIT_PER_RESET;
         gap_period = GAP_PER_RESET;
         linked = 1'b0;
         blink_phase = 1'b0;
         gap_next = 1'b0;
         done = 1'b0;
         blink_count = '0;
         digit_count = DIGIT_RESET;
         foreach (addr_text[i]) addr_text[i] = '0;
         text_pos = 0;
         colour = COLOUR_RED;
         recolour('0, '0);
         errors = 0;
         checked = 0;
         done_events = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [15:0] value);
         case (index)
            REG_AP_MODE: ap_mode = value[0];
            REG_BLINK_PER: blink_period = value;
            REG_AMBER_PER: amber_period = value;
            REG_DIGIT_PER: digit_period = value;
            REG_GAP_PER: gap_period = value;
            default: ;
         endcase
      endfunction

      // A new background on both strips always drops the highlight.
      function void recolour(rgb_type strip1, rgb_type strip2);
         fill1 = strip1;
         fill2 = strip2;
         lit_mask = '0;
         lit_rgb = '0;
      endfunction

      // Positions past the end of the text read as a terminator.
      function logic [7:0] char_at(int p);
         return (p >= TEXT_LEN) ? 8'h00 : addr_text[p];
      endfunction

      function logic [LED_COUNT-1:0] digit_leds(logic [7:0] c);
         logic [31:0] m;
         int n;
         m = '0;
         n = int'(c) - int'(CHAR_ZERO);
         if (c >= CHAR_ONE && c <= CHAR_FIVE) begin
            m = (32'd1 << n) - 32'd1;
         end else if (c >= CHAR_SIX && c <= CHAR_NINE) begin
            m = 32'h1F | (((32'd1 << (n - 5)) - 32'd1) << 8);
         end else if (c == CHAR_DOT) begin
            m = (32'd1 << 0) | (32'd1 << 5) | (32'd1 << 10);
         end
         return m[LED_COUNT-1:0];
      endfunction

      // One tick of the address display: a digit, then a grey gap.
      function void address_step();
         logic [7:0] c;
         rgb_type hue;
         digit_count = digit_count - 16'd1;
         if (digit_count != 16'd0) return;
         if (gap_next) begin
            recolour({GAP_GREY, GAP_GREY, GAP_GREY}, {GAP_GREY, GAP_GREY, GAP_GREY});
            digit_count = gap_period;
            gap_next = 1'b0;
            return;
         end
         gap_next = 1'b1;
         digit_count = digit_period;
         // The terminator restarts the text in the next color.
         if (char_at(text_pos) == 8'h00) begin
            text_pos = 0;
            if (colour == COLOUR_BLUE) begin
               colour = COLOUR_RED;
               done = 1'b1;
               done_events++;
            end else begin
               colour = colour + 2'd1;
            end
         end
         recolour('0, '0);
         c = char_at(text_pos);
         text_pos++;
         hue = '0;
         case (colour)
            COLOUR_RED: hue.red = FULL_LEVEL;
            COLOUR_GREEN: hue.green = FULL_LEVEL;
            default: hue.blue = FULL_LEVEL;
         endcase
         if (c == CHAR_DOT) hue = {DOT_GREY, DOT_GREY, DOT_GREY};
         lit_mask = digit_leds(c);
         if (lit_mask != '0) lit_rgb = hue;
      endfunction

      // One tick of the blink patterns.
      function void blink_step();
         rgb_type cyan, blue, amber;
         cyan = {8'd0, DIM_LEVEL, DIM_LEVEL};
         blue = {8'd0, 8'd0, DIM_LEVEL};
         amber = {DIM_LEVEL, AMBER_GREEN, 8'd0};
         if (blink_count != 16'd0) begin
            blink_count = blink_count - 16'd1;
            return;
         end
         if (ap_mode) begin
            blink_count = blink_period;
            if (linked) begin
               if (!blink_phase) recolour(cyan, cyan);
               else recolour('0, '0);
            end else begin
               if (!blink_phase) recolour(blue, '0);
               else recolour('0, blue);
            end
         end else if (!blink_phase) begin
            blink_count = amber_period;
            recolour(amber, amber);
         end else begin
            blink_count = blink_period;
            recolour('0, '0);
         end
         blink_phase = ~blink_phase;
      endfunction

      // Applies an accepted request word and queues the strip contents it leaves.
      function void note_request(req_word_type w);
         rsp_word_type e;
         logic show;
         show = 1'b0;
         case (w.cmd)
            CMD_TICK: begin
               if (!ap_mode && linked) address_step();
               else blink_step();
               show = 1'b1;
            end
            CMD_LINK: begin
               if (w.link_up) begin
                  text_pos = 0;
                  colour = COLOUR_RED;
                  done = 1'b0;
                  digit_count = digit_period;
                  gap_next = 1'b0;
               end
               linked = w.link_up;
            end
            CMD_CHAR: addr_text[w.char_index] = w.char_code;
            default: ;
         endcase
         e.show = show;
         e.fill1_red = fill1.red;
         e.fill1_green = fill1.green;
         e.fill1_blue = fill1.blue;
         e.fill2_red = fill2.red;
         e.fill2_green = fill2.green;
         e.fill2_blue = fill2.blue;
         e.lit_mask = lit_mask;
         e.lit_red = lit_rgb.red;
         e.lit_green = lit_rgb.green;
         e.lit_blue = lit_rgb.blue;
         e.cycle_done = done;
         expected_strips.push_back(e);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      // Checks one result word against the oldest pending expectation.
      function void check_strips(rsp_word_type got);
         rsp_word_type want;
         if (expected_strips.size() == 0) begin
            $error("result word 0x%h arrived with nothing expected", got);
            errors++;
            return;
         end
         want = expected_strips.pop_front();
         checked++;
         compare_field("show", 16'(want.show), 16'(got.show));
         compare_field("fill1_red", 16'(want.fill1_red), 16'(got.fill1_red));
         compare_field("fill1_green", 16'(want.fill1_green), 16'(got.fill1_green));
         compare_field("fill1_blue", 16'(want.fill1_blue), 16'(got.fill1_blue));
         compare_field("fill2_red", 16'(want.fill2_red), 16'(got.fill2_red));
         compare_field("fill2_green", 16'(want.fill2_green), 16'(got.fill2_green));
         compare_field("fill2_blue", 16'(want.fill2_blue), 16'(got.fill2_blue));
         compare_field("lit_mask", 16'(want.lit_mask), 16'(got.lit_mask));
         compare_field("lit_red", 16'(want.lit_red), 16'(got.lit_red));
         compare_field("lit_green", 16'(want.lit_green), 16'(got.lit_green));
         compare_field("lit_blue", 16'(want.lit_blue), 16'(got.lit_blue));
         compare_field("cycle_done", 16'(want.cycle_done), 16'(got.cycle_done));
      endfunction

      function int pending();
         return expected_strips.size();
      endfunction

      function void close_out();
         if (expected_strips.size() != 0) begin
            $error("%0d expected result words never arrived", expected_strips.size());
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, csr_we;
   req_word_type req_word;
   rsp_word_type rsp_word;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [15:0] csr_wdata;

   strip_predictor strips;
   bit req_idle_on, rsp_idle_on;
   int stall_left;
   int words_sent, ticks_sent, settings_used;

   status_led_blink_and_ip_digit_sequencer #(
      .TEXT_LEN(TEXT_LEN)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Receiver backpressure comes in random bursts while enabled.
   always @(negedge clock) begin
      if (reset || !rsp_idle_on) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Every accepted result word is checked at the clock edge that takes it.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) strips.check_strips(rsp_word);
   end

   function automatic req_word_type tick_word();
      req_word_type w;
      w = '0;
      w.cmd = CMD_TICK;
      return w;
   endfunction

   function automatic req_word_type link_word(logic up);
      req_word_type w;
      w = '0;
      w.cmd = CMD_LINK;
      w.link_up = up;
      return w;
   endfunction

   function automatic req_word_type char_word(logic [3:0] index, logic [7:0] code);
      req_word_type w;
      w = '0;
      w.cmd = CMD_CHAR;
      w.char_index = index;
      w.char_code = code;
      return w;
   endfunction

   function automatic req_word_type noise_word();
      req_word_type w;
      w = 15'($urandom_range(0, 32767));
      return w;
   endfunction

   // Mostly digits and dots; a few arbitrary bytes unless only digits and dots are wanted.
   function automatic logic [7:0] text_char(logic digits_only);
      int r;
      r = $urandom_range(0, digits_only ? 10 : 13);
      if (r < 10) return CHAR_ZERO + 8'(r);
      if (r == 10) return CHAR_DOT;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      c.ap_mode = ($urandom_range(0, 2) == 0);
      c.blink_period = 16'($urandom_range(0, 6));
      c.amber_on_period = 16'($urandom_range(0, 6));
      c.digit_period = 16'($urandom_range(1, 4));
      c.gap_period = 16'($urandom_range(1, 4));
      return c;
   endfunction

   // Offers one word, with an optional idle burst ahead of it, and waits until it is taken.
   task automatic send_word(req_word_type w);
      int gap;
      if (req_idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall !== 1'b0);
      strips.note_request(w);
      words_sent++;
      if (w.cmd == CMD_TICK) ticks_sent++;
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      strips.write_reg(index, value);
   endtask

   // Registers change only once the block has drained every pending word.
   task automatic write_settings(cfg_type c);
      @(negedge clock);
      req_valid <= 1'b0;
      while (strips.pending() != 0) @(posedge clock);
      write_reg(REG_AP_MODE, {15'd0, c.ap_mode});
      write_reg(REG_BLINK_PER, c.blink_period);
      write_reg(REG_AMBER_PER, c.amber_on_period);
      write_reg(REG_DIGIT_PER, c.digit_period);
      write_reg(REG_GAP_PER, c.gap_period);
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Writes an address, usually connects and lets the digits run, with a little noise mixed in.
   task automatic address_burst();
      int len, ticks, r;
      r = $urandom_range(0, 9);
      len = (r < 6) ? $urandom_range(1, 5) : ((r < 8) ? $urandom_range(6, 15) : TEXT_LEN);
      for (int i = 0; i < len; i++) send_word(char_word(4'(i), text_char(len == TEXT_LEN)));
      if (len < TEXT_LEN && $urandom_range(0, 4) != 0) send_word(char_word(4'(len), 8'h00));
      if ($urandom_range(0, 9) != 0) send_word(link_word(1'b1));
      ticks = $urandom_range(30, 160);
      for (int i = 0; i < ticks; i++) begin
         if ($urandom_range(0, 24) == 0) send_word(noise_word());
         else send_word(tick_word());
      end
   endtask

   task automatic blink_burst();
      if ($urandom_range(0, 1) == 1) send_word(link_word(1'($urandom_range(0, 1))));
      repeat ($urandom_range(5, 40)) send_word(tick_word());
   endtask

   initial begin
      cfg_type c;
      req_word_type odd;
      int phase, phase_end, spins, r;
      bit last_phase;
      strips = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      words_sent = 0;
      ticks_sent = 0;
      settings_used = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: zero blink reloads and single-tick digits and gaps.
      c = '0;
      c.digit_period = 16'd1;
      c.gap_period = 16'd1;
      write_settings(c);
      send_word(tick_word());
      send_word(tick_word());
      odd = '1;
      odd.cmd = CMD_UNUSED;
      send_word(odd);
      send_word(char_word(4'd0, CHAR_ONE));
      send_word(char_word(4'd1, CHAR_FIVE));
      send_word(char_word(4'd2, CHAR_SIX));
      send_word(char_word(4'd3, CHAR_NINE));
      send_word(char_word(4'd4, CHAR_DOT));
      send_word(char_word(4'd5, 8'h41));
      send_word(char_word(4'd6, 8'h00));
      send_word(char_word(4'd15, 8'hFF));
      send_word(link_word(1'b1));
      repeat (10) send_word(tick_word());
      send_word(link_word(1'b0));
      send_word(tick_word());

      // Random part: phases of register settings, the last one with maximal blink reloads.
      // Phases overrun their nominal length, so the last one starts two phases early.
      phase = 0;
      last_phase = 1'b0;
      while (!last_phase) begin
         last_phase = (words_sent >= ITEMS_TARGET - 2 * PHASE_WORDS);
         c = random_settings();
         if (last_phase) begin
            c.ap_mode = 1'b0;
            c.blink_period = 16'hFFFF;
            c.amber_on_period = 16'hFFFF;
         end else begin
            case (phase)
               1: c.digit_period = 16'hFFFF;
               2: c.gap_period = 16'hFFFF;
               3: c.ap_mode = 1'b1;
               default: ;
            endcase
         end
         write_settings(c);
         phase_end = words_sent + PHASE_WORDS;
         while (words_sent < phase_end) begin
            req_idle_on = !last_phase && $urandom_range(0, 3) != 0;
            rsp_idle_on = !last_phase && $urandom_range(0, 3) != 0;
            r = $urandom_range(0, 19);
            if (r < 11) begin
               address_burst();
            end else if (r < 17) begin
               blink_burst();
            end else begin
               repeat ($urandom_range(1, 8)) send_word(noise_word());
            end
         end
         phase++;
      end

      // Drain the last results and catch any stray result word before closing out.
      @(negedge clock);
      req_valid <= 1'b0;
      spins = 0;
      while (strips.pending() != 0 && spins < DRAIN_LIMIT) begin
         @(posedge clock);
         spins++;
      end
      repeat (4) @(posedge clock);
      strips.close_out();
      $display("Sent %0d request words (%0d ticks) over %0d register settings; %0d results checked.",
               words_sent, ticks_sent, settings_used, strips.checked);
      $display("The address display finished its three-color cycle %0d times.",
               strips.done_events);
      if (strips.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Hard stop in case the handshakes hang.
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: files.f
rtl/sls_pkg.sv
rtl/sls_text_store.sv
rtl/sls_pattern_engine.sv
rtl/status_led_blink_and_ip_digit_sequencer.sv
tb/sv/status_led_blink_and_ip_digit_sequencer_tb.sv
